FILE: rtl/core/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Shared widths and constants for the string hash to bucket core.
// ----------------------------------------------------------------------------
package shb_pkg;

    localparam int HASH_W = 32;
    localparam int TS_W   = 21;
    localparam int IDX_W  = 20;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = $clog2(HASH_W);
    localparam int REM_W  = TS_W + 1;

    localparam logic [TS_W-1:0] TS_MAX   = TS_W'(1048576);
    localparam logic [TS_W-1:0] TS_RESET = TS_W'(1024);
    localparam logic [TS_W-1:0] TS_ONE   = TS_W'(1);

    // handshake between the sequencer and the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: rtl/core/string_hash_to_bucket_core.sv
// ----------------------------------------------------------------------------
// string_hash_to_bucket_core
// Base-31 polynomial string hash, one character per beat, reduced to a bucket.
// ----------------------------------------------------------------------------
// channel   direction  signals                                  beat
// in        sink       in_valid in_ready char_byte has_char last one key item
// out       source     out_valid out_ready bucket_index          one bucket
// cfg       sink       cfg_valid cfg_ready table_size            table size
//
// a character beat folds in the cycle it is accepted; in_ready stays high
// a last beat starts the remainder unit, which takes the dividend one bit at a time
// before its remainder loads the output register; in_ready is low meanwhile
// a stalled output holds its bucket while the next key folds in; a remainder
// finished under that stall waits in the unit with in_ready low until it goes
// reset clears the hash, the sequencer and sets table size to 1024
// ----------------------------------------------------------------------------
module string_hash_to_bucket_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [shb_pkg::CHAR_W-1:0] char_byte,
    input  logic                       has_char,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [shb_pkg::IDX_W-1:0]  bucket_index,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [shb_pkg::TS_W-1:0]   table_size
);
    import shb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [TS_W-1:0]   ts_reg;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;

    logic              in_beat;
    logic              div_start;
    logic [HASH_W-1:0] hash_fold;
    logic [HASH_W-1:0] hash_mag;
    logic [TS_W-1:0]   div_eff;
    logic              out_free;
    div_status_t       div_status;
    logic [IDX_W-1:0]  div_rem;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign div_start = in_beat && last;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // 31*h = 32*h - h, plus the sign-extended character
    always_comb
    begin
        hash_fold = hash_reg;
        if (has_char)
            hash_fold = ({hash_reg[HASH_W-6:0], 5'b0} - hash_reg)
                        + {{(HASH_W-CHAR_W){char_byte[CHAR_W-1]}}, char_byte};
    end

    // -2^31 maps onto 2^31 as an unsigned magnitude
    assign hash_mag = hash_fold[HASH_W-1] ? (HASH_W'(0) - hash_fold) : hash_fold;

    always_comb
    begin
        if (ts_reg == '0)
            div_eff = TS_ONE;
        else if (ts_reg > TS_MAX)
            div_eff = TS_MAX;
        else
            div_eff = ts_reg;
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (in_beat)
            hash_next = last ? '0 : hash_fold;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = div_rem;
                        state_next     = ST_IDLE;
                    end
                    else
                        state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = div_rem;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            ts_reg        <= TS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                ts_reg <= table_size;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg <= out_idx_next;
    end

    shb_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (hash_mag),
        .divisor   (div_eff),
        .status    (div_status),
        .remainder (div_rem)
    );

    assign out_valid    = out_valid_reg;
    assign bucket_index = out_idx_reg;

endmodule

FILE: rtl/core/shb_divider.sv
// ----------------------------------------------------------------------------
// shb_divider
// Restoring shift-subtract remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module shb_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [shb_pkg::HASH_W-1:0] dividend,
    input  logic [shb_pkg::TS_W-1:0]   divisor,
    output shb_pkg::div_status_t       status,
    output logic [shb_pkg::IDX_W-1:0]  remainder
);
    import shb_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [HASH_W-1:0]  dvd_reg, dvd_next;
    logic [TS_W-1:0]    div_reg, div_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   rem_shift;

    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[HASH_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(HASH_W - 1);
            dvd_next   = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            if (rem_shift >= {1'b0, div_reg})
                rem_next = rem_shift - {1'b0, div_reg};
            else
                rem_next = rem_shift;
            count_next = count_reg - CNT_W'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    // remainder stays below a divisor of at most 2^20
    assign remainder   = rem_reg[IDX_W-1:0];

endmodule

FILE: rtl/core/shb_checker.sv
// ----------------------------------------------------------------------------
// shb_checker
// Port-level checks on the string hash to bucket core, bound to the top.
// ----------------------------------------------------------------------------
module shb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [shb_pkg::CHAR_W-1:0] char_byte,
    input logic                       has_char,
    input logic                       last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [shb_pkg::IDX_W-1:0]  bucket_index,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [shb_pkg::TS_W-1:0]   table_size
);
    import shb_pkg::*;

    // a stalled bucket holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bucket_index))
        else $error("bucket beat changed while stalled");

    // finishing a key stops intake while the remainder runs
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("intake open right after a last beat");

    // character beats never stall the next one
    a_char_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last |=> in_ready)
        else $error("intake closed after a character beat");

    // a bucket only appears at the end of a busy stretch
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("bucket appeared without a finished key");

endmodule

bind string_hash_to_bucket_core shb_checker u_shb_checker (.*);
